>>> rtl/core/trss_pkg.sv
// ----------------------------------------------------------------------------
// trss_pkg: shared types and constants for the tared seven-segment readout
// Item structs, function codes, division constants and the segment table.
// ----------------------------------------------------------------------------
package trss_pkg;

  localparam int CODE_W  = 24;
  localparam int FUNC_W  = 2;
  localparam int DIGIT_W = 4;
  localparam int SEG_W   = 7;
  localparam int EN_W    = 4;
  localparam int SCAN_W  = 2;
  localparam int QUO_W   = 11;   // mag / 10000 is at most 1677

  localparam int QUEUE_DEPTH = 4;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TARE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SCAN   = 2'd2;

  // scan positions
  localparam logic [SCAN_W-1:0] POS_SIGN     = 2'd0;
  localparam logic [SCAN_W-1:0] POS_HUNDREDS = 2'd1;
  localparam logic [SCAN_W-1:0] POS_TENS     = 2'd2;
  localparam logic [SCAN_W-1:0] POS_ONES     = 2'd3;

  localparam logic [CODE_W-1:0] CODE_FLIP = 24'h80_0000;

  // mag / 10000: estimate by reciprocal, then one correction step
  localparam logic [15:0] RECIP_10000     = 16'd53687;   // floor(2^29 / 10000)
  localparam int          RECIP_SHIFT     = 29;
  localparam logic [13:0] COUNTS_PER_UNIT = 14'd10000;

  // q / 10, exact for q < 43690
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;
  // q / 10, exact for q < 1029
  localparam logic [7:0]  DIV10_SMALL_MUL   = 8'd205;
  localparam int          DIV10_SMALL_SHIFT = 11;
  localparam logic [3:0]  TEN = 4'd10;

  localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;
  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CODE_W-1:0] raw_code;
  } in_item_t;

  typedef struct packed {
    logic [EN_W-1:0]  digit_enable_n;
    logic [SEG_W-1:0] segments;
  } out_item_t;

  // queue entry between front and back
  typedef struct packed {
    logic              is_scan;
    logic              neg;
    logic [CODE_W-1:0] mag;
  } work_t;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = SEG_BLANK;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/core/trss_front.sv
// ----------------------------------------------------------------------------
// trss_front: input side of the tared readout
// Flips the code, holds the tare baseline, forms sign and magnitude.
// ----------------------------------------------------------------------------
module trss_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  trss_pkg::in_item_t in_item,
  output logic               push_valid,
  input  logic               push_ready,
  output trss_pkg::work_t    push_entry
);

  logic [trss_pkg::CODE_W-1:0] baseline;
  logic [trss_pkg::CODE_W-1:0] code;
  logic [trss_pkg::CODE_W:0]   diff;
  logic                        accept;
  logic                        is_sample;
  logic                        is_scan;

  assign code      = in_item.raw_code ^ trss_pkg::CODE_FLIP;
  assign is_sample = (in_item.func == trss_pkg::FUNC_SAMPLE);
  assign is_scan   = (in_item.func == trss_pkg::FUNC_SCAN);
  assign in_ready  = push_ready;
  assign accept    = in_valid && in_ready;

  assign diff = {1'b0, code} - {1'b0, baseline};

  // tare and unused codes never enter the queue
  assign push_valid         = in_valid && (is_sample || is_scan);
  assign push_entry.is_scan = is_scan;
  assign push_entry.neg     = diff[trss_pkg::CODE_W];
  assign push_entry.mag     = diff[trss_pkg::CODE_W] ? (baseline - code) : (code - baseline);

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= '0;
    end else if (accept && (in_item.func == trss_pkg::FUNC_TARE)) begin
      baseline <= code;
    end
  end

endmodule

>>> rtl/core/trss_queue.sv
// ----------------------------------------------------------------------------
// trss_queue: short FIFO between front and back
// Register-based ring, valid/ready on both sides.
// ----------------------------------------------------------------------------
module trss_queue #(
  parameter int DEPTH = trss_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  trss_pkg::work_t push_entry,
  output logic            pop_valid,
  input  logic            pop_ready,
  output trss_pkg::work_t pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  trss_pkg::work_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/trss_back.sv
// ----------------------------------------------------------------------------
// trss_back: divide, digit split and display scan
// Four pipeline stages, commit of digits and scan output at the end.
// ----------------------------------------------------------------------------
module trss_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  trss_pkg::work_t     pop_entry,
  output logic                out_valid,
  input  logic                out_ready,
  output trss_pkg::out_item_t out_item
);

  localparam int CW   = trss_pkg::CODE_W;
  localparam int QW   = trss_pkg::QUO_W;
  localparam int DW   = trss_pkg::DIGIT_W;
  localparam int P1_W = CW + 16;
  localparam int Q1_W = 8;
  localparam int Q2_W = 5;
  localparam int RECIP_HI = trss_pkg::RECIP_SHIFT + QW;

  // stage 1: reciprocal product
  logic            s1_valid;
  logic            s1_is_scan;
  logic            s1_neg;
  logic [CW-1:0]   s1_mag;
  logic [P1_W-1:0] s1_prod;
  // stage 2: corrected quotient
  logic            s2_valid;
  logic            s2_is_scan;
  logic            s2_neg;
  logic [QW-1:0]   s2_q;
  // stage 3: q / 10
  logic            s3_valid;
  logic            s3_is_scan;
  logic            s3_neg;
  logic [QW-1:0]   s3_q;
  logic [Q1_W-1:0] s3_q1;
  // stage 4: ones digit and q / 100
  logic            s4_valid;
  logic            s4_is_scan;
  logic            s4_neg;
  logic [DW-1:0]   s4_ones;
  logic [Q1_W-1:0] s4_q1;
  logic [Q2_W-1:0] s4_q2;

  // committed display state
  logic                                is_negative;
  logic [DW-1:0]                       hundreds_digit;
  logic [DW-1:0]                       tens_digit;
  logic [DW-1:0]                       ones_digit;
  logic [trss_pkg::SCAN_W-1:0]         scan_index;

  logic            adv;
  logic [QW-1:0]   q0;
  logic [CW:0]     rem;
  logic [QW-1:0]   q_fix;
  logic [26:0]     div10_prod;
  logic [15:0]     div10s_prod;
  logic [DW-1:0]   tens_calc;
  logic [DW-1:0]   hundreds_calc;
  logic [trss_pkg::SEG_W-1:0] seg_sel;
  logic            any_digit;

  // whole pipe holds only when a scan result cannot leave
  assign adv       = !(s4_valid && s4_is_scan && out_valid && !out_ready);
  assign pop_ready = adv;

  assign q0    = s1_prod[RECIP_HI-1:trss_pkg::RECIP_SHIFT];
  assign rem   = {1'b0, s1_mag} - (CW + 1)'(q0 * trss_pkg::COUNTS_PER_UNIT);
  assign q_fix = (rem >= (CW + 1)'(trss_pkg::COUNTS_PER_UNIT)) ? q0 + 1'b1 : q0;

  assign div10_prod  = 27'(s2_q) * 27'(trss_pkg::DIV10_MUL);
  assign div10s_prod = 16'(s3_q1) * 16'(trss_pkg::DIV10_SMALL_MUL);

  assign tens_calc     = DW'(s4_q1 - Q1_W'(s4_q2 * trss_pkg::TEN));
  assign hundreds_calc = (s4_q2 >= Q2_W'(trss_pkg::TEN)) ? DW'(s4_q2 - Q2_W'(trss_pkg::TEN))
                                                         : DW'(s4_q2);

  assign any_digit = (hundreds_digit | tens_digit | ones_digit) != '0;

  always_comb begin
    case (scan_index)
      trss_pkg::POS_SIGN:     seg_sel = (is_negative && any_digit) ? trss_pkg::SEG_MINUS
                                                                  : trss_pkg::SEG_BLANK;
      trss_pkg::POS_HUNDREDS: seg_sel = trss_pkg::seg_pattern(hundreds_digit);
      trss_pkg::POS_TENS:     seg_sel = trss_pkg::seg_pattern(tens_digit);
      trss_pkg::POS_ONES:     seg_sel = trss_pkg::seg_pattern(ones_digit);
      default:                seg_sel = trss_pkg::SEG_BLANK;
    endcase
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_is_scan <= pop_entry.is_scan;
      s1_neg     <= pop_entry.neg;
      s1_mag     <= pop_entry.mag;
      s1_prod    <= P1_W'(pop_entry.mag) * P1_W'(trss_pkg::RECIP_10000);
      s2_is_scan <= s1_is_scan;
      s2_neg     <= s1_neg;
      s2_q       <= q_fix;
      s3_is_scan <= s2_is_scan;
      s3_neg     <= s2_neg;
      s3_q       <= s2_q;
      s3_q1      <= div10_prod[trss_pkg::DIV10_SHIFT+Q1_W-1:trss_pkg::DIV10_SHIFT];
      s4_is_scan <= s3_is_scan;
      s4_neg     <= s3_neg;
      s4_ones    <= DW'(s3_q - QW'(s3_q1 * trss_pkg::TEN));
      s4_q1      <= s3_q1;
      s4_q2      <= div10s_prod[trss_pkg::DIV10_SMALL_SHIFT+Q2_W-1:trss_pkg::DIV10_SMALL_SHIFT];
    end
  end

  // stage valids, committed state, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      s3_valid       <= 1'b0;
      s4_valid       <= 1'b0;
      is_negative    <= 1'b0;
      hundreds_digit <= '0;
      tens_digit     <= '0;
      ones_digit     <= '0;
      scan_index     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        s1_valid <= pop_valid;
        s2_valid <= s1_valid;
        s3_valid <= s2_valid;
        s4_valid <= s3_valid;
        if (s4_valid && !s4_is_scan) begin
          is_negative    <= s4_neg;
          hundreds_digit <= hundreds_calc;
          tens_digit     <= tens_calc;
          ones_digit     <= s4_ones;
        end
        if (s4_valid && s4_is_scan) begin
          out_valid  <= 1'b1;
          scan_index <= scan_index + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s4_valid && s4_is_scan) begin
      out_item.digit_enable_n <= ~(trss_pkg::EN_W'(1) << scan_index);
      out_item.segments       <= seg_sel;
    end
  end

endmodule

>>> rtl/core/tared_readout_seven_segment_scan.sv
// ----------------------------------------------------------------------------
// tared_readout_seven_segment_scan: tared readout on a 4-digit LED display
// Front, queue and back joined; one item per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless a scan result stalls at the output;
//   set by the combinational front subtract and fully pipelined back divide.
// Path: an empty path takes a scan tick through a queue write, the four
//   divide stages and the output register.
// Reset: synchronous, active high; clears baseline, digits, sign, scan
//   position, queue and all valid flags. No clearing pass.
module tared_readout_seven_segment_scan #(
  parameter int QUEUE_DEPTH = trss_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  trss_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output trss_pkg::out_item_t out_item
);

  // Front: flips the code (two's complement to offset binary), keeps the tare
  // baseline, and turns a sample into sign and magnitude. Tare and unused
  // codes end in the front; samples and scan ticks go on in order.
  logic            push_valid;
  logic            push_ready;
  trss_pkg::work_t push_entry;

  // Back side of the queue.
  logic            pop_valid;
  logic            pop_ready;
  trss_pkg::work_t pop_entry;

  trss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // Short queue so an output stall does not stop tare transfers at once.
  trss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Back: divides the magnitude by 10000 with a reciprocal multiply and one
  // correction, splits the quotient into ones, tens and hundreds (thousands
  // dropped), and commits them in order with scan ticks. A scan tick reads
  // the committed digits, loads the output register and steps the scan.
  trss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> rtl/core/trss_checker.sv
// ----------------------------------------------------------------------------
// trss_checker: port-level checks for the tared readout
// Output stability, digit select shape and segment content.
// ----------------------------------------------------------------------------
module trss_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input trss_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input trss_pkg::out_item_t out_item
);

  // a pending result holds until transferred
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output changed while stalled");

  // exactly one digit selected
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(~out_item.digit_enable_n))
    else $error("digit select not one-hot low");

  // sign position shows blank or minus only
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.digit_enable_n[0] |->
      (out_item.segments == trss_pkg::SEG_BLANK) ||
      (out_item.segments == trss_pkg::SEG_MINUS))
    else $error("bad sign position pattern");

  // numeric positions always light something
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.digit_enable_n[0] |-> out_item.segments != trss_pkg::SEG_BLANK)
    else $error("blank numeric digit");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  logic unused_in;
  assign unused_in = in_valid ^ in_ready ^ (^in_item);

endmodule

bind tared_readout_seven_segment_scan trss_checker u_trss_checker (.*);

>>> verif/trss_checker.sv
// ----------------------------------------------------------------------------
// trss_scoreboard: scoreboard for the tared seven-segment readout
// Watches both channels and predicts each scan-tick display drive from the
// accepted transfers. Compares drives in order and counts mismatches.
// ----------------------------------------------------------------------------
module trss_scoreboard
  import trss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  localparam int unsigned COUNTS_PER_DIGIT = 10000;

  // shadow of the readout state
  logic [CODE_W-1:0]  tare_level;
  logic               below_tare;
  logic [DIGIT_W-1:0] hundreds;
  logic [DIGIT_W-1:0] tens;
  logic [DIGIT_W-1:0] ones;
  logic [SCAN_W-1:0]  scan_pos;

  out_item_t drive_expect[$];
  int        mismatches = 0;

  task automatic flag(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    case (d)
      4'd0:    return 7'b011_1111;
      4'd1:    return 7'b000_0110;
      4'd2:    return 7'b101_1011;
      4'd3:    return 7'b100_1111;
      4'd4:    return 7'b110_0110;
      4'd5:    return 7'b110_1101;
      4'd6:    return 7'b111_1101;
      4'd7:    return 7'b000_0111;
      4'd8:    return 7'b111_1111;
      4'd9:    return 7'b110_1111;
      default: return 7'b000_0000;
    endcase
  endfunction

  task automatic advance_readout(input in_item_t it);
    logic [CODE_W-1:0] level;
    logic [CODE_W-1:0] mag;
    int unsigned       units;
    out_item_t         drive;
    level = it.raw_code ^ CODE_FLIP;
    case (it.func)
      FUNC_TARE: begin
        tare_level = level;
      end
      FUNC_SAMPLE: begin
        below_tare = (level < tare_level);
        mag        = below_tare ? tare_level - level : level - tare_level;
        units      = mag / COUNTS_PER_DIGIT;
        ones       = DIGIT_W'(units % 10);
        tens       = DIGIT_W'((units / 10) % 10);
        hundreds   = DIGIT_W'((units / 100) % 10);  // thousands dropped
      end
      FUNC_SCAN: begin
        drive.digit_enable_n = ~(EN_W'(1) << scan_pos);
        case (scan_pos)
          POS_SIGN: begin
            drive.segments = (below_tare && (hundreds | tens | ones) != 0) ?
                             SEG_MINUS : SEG_BLANK;
          end
          POS_HUNDREDS: drive.segments = glyph(hundreds);
          POS_TENS:     drive.segments = glyph(tens);
          default:      drive.segments = glyph(ones);
        endcase
        drive_expect.push_back(drive);
        scan_pos = scan_pos + 1'b1;
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      tare_level = '0;
      below_tare = 1'b0;
      hundreds   = '0;
      tens       = '0;
      ones       = '0;
      scan_pos   = '0;
      drive_expect.delete();
    end else begin
      // compare first: a drive never comes from a transfer at the same edge
      if (out_valid && out_ready) begin
        if (drive_expect.size() == 0) begin
          flag($sformatf("unexpected drive en=%h seg=%h",
                         out_item.digit_enable_n, out_item.segments));
        end else begin
          want = drive_expect.pop_front();
          if (out_item.digit_enable_n !== want.digit_enable_n) begin
            flag($sformatf("digit_enable_n got %h want %h",
                           out_item.digit_enable_n, want.digit_enable_n));
          end
          if (out_item.segments !== want.segments) begin
            flag($sformatf("segments got %h want %h (en %h)",
                           out_item.segments, want.segments, want.digit_enable_n));
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_readout(in_item);
      end
    end
    fail_count <= mismatches;
    pending    <= drive_expect.size();
  end

endmodule

>>> verif/tared_readout_seven_segment_scan_tb.sv
// ----------------------------------------------------------------------------
// tared_readout_seven_segment_scan_tb: top-level bench for the tared readout
// Directed corner transfers, then random tare/sample/scan/unused traffic with
// random idle bursts on both channels; trss_scoreboard predicts and checks.
// ----------------------------------------------------------------------------
module tared_readout_seven_segment_scan_tb;
  import trss_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 490;   // counts only transfers with an effect
  localparam int CALM_ITEMS   = 80;    // tail of the run with no idling
  localparam int DRAIN_CYCLES = 12;    // extra wait after the last expected drive
  localparam int STALL_LIMIT  = 1000;  // cycles with no transfer at all

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  bit                calm     = 1'b0;  // set for the tail: no gaps, no stalls
  logic [CODE_W-1:0] tare_raw = '0;    // raw code of the last tare sent

  // 20-unit clock period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tared_readout_seven_segment_scan dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  trss_scoreboard u_scoreboard (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // One transfer on the input channel. An optional idle burst comes first;
  // valid then holds with a fixed payload until the handshake completes.
  // in_ready is read right after the edge, i.e. the value the edge saw.
  task automatic push_reading(input logic [FUNC_W-1:0] f,
                              input logic [CODE_W-1:0] raw);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{func: f, raw_code: raw};
    if (f == FUNC_TARE) tare_raw = raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Display-side back-pressure: random stall bursts between runs of ready,
  // which are sometimes long enough to give stall-free stretches.
  initial begin : drive_sink
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int                effective;
    int unsigned       pick;
    logic [CODE_W-1:0] span;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part ---
    // reading exactly at the tare: zero magnitude, sign cleared
    push_reading(FUNC_TARE, 24'h80_0000);
    push_reading(FUNC_SAMPLE, 24'h80_0000);
    repeat (4) push_reading(FUNC_SCAN, 24'($urandom()));
    // widest spread below the tare: quotient 1677, leading 1 dropped, minus
    push_reading(FUNC_TARE, 24'h7F_FFFF);
    push_reading(FUNC_SAMPLE, 24'h80_0000);
    repeat (4) push_reading(FUNC_SCAN, 24'hFF_FFFF);
    // unused function code must leave the scan position alone
    push_reading(FUNC_UNUSED, 24'hFF_FFFF);
    push_reading(FUNC_SCAN, 24'h00_0000);
    // slightly below the tare: negative but all kept digits zero, blank sign
    push_reading(FUNC_TARE, 24'hFF_FFFF);
    push_reading(FUNC_SAMPLE, 24'hFF_FFF0);
    repeat (4) push_reading(FUNC_SCAN, 24'($urandom()));
    // one count above the tare, then half scale above it
    push_reading(FUNC_SAMPLE, 24'h00_0000);
    push_reading(FUNC_SCAN, 24'h55_5555);
    push_reading(FUNC_SAMPLE, 24'h7F_FFFF);
    repeat (3) push_reading(FUNC_SCAN, 24'hAA_AAAA);

    // --- random part ---
    // Samples are mostly near the current tare so that small and mid readings
    // (and both signs) come up often; the other samples are full-range noise.
    effective = 0;
    while (effective < RANDOM_ITEMS) begin
      if (effective == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        push_reading(FUNC_SCAN, 24'($urandom()));
      end else if (pick < 70) begin
        case ($urandom_range(0, 2))
          0:       span = 24'($urandom_range(0, 20000));
          1:       span = 24'($urandom_range(0, 2000000));
          default: span = 24'($urandom());
        endcase
        if ($urandom_range(0, 1) == 0) push_reading(FUNC_SAMPLE, tare_raw + span);
        else push_reading(FUNC_SAMPLE, tare_raw - span);
      end else if (pick < 82) begin
        push_reading(FUNC_SAMPLE, 24'($urandom()));
      end else if (pick < 94) begin
        push_reading(FUNC_TARE, 24'($urandom()));
      end else begin
        push_reading(FUNC_UNUSED, 24'($urandom()));
      end
      if (pick < 94) effective++;
    end
    in_valid <= 1'b0;

    // let the scoreboard see the last transfer, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/trss_pkg.sv
rtl/core/trss_front.sv
rtl/core/trss_queue.sv
rtl/core/trss_back.sv
rtl/core/tared_readout_seven_segment_scan.sv
rtl/core/trss_checker.sv
verif/trss_checker.sv
verif/tared_readout_seven_segment_scan_tb.sv
